@@ hdl/lrb_pkg.sv @@
// shared types and codes for the link reconnect backoff controller
package lrb_pkg;

  typedef enum logic [3:0] {
    EV_START     = 4'd0,
    EV_STAUP     = 4'd1,
    EV_GOTIP     = 4'd2,
    EV_DISC      = 4'd3,
    EV_POLL      = 4'd4,
    EV_RECOVER   = 4'd5,
    EV_BEGINONB  = 4'd6,
    EV_CAND      = 4'd7,
    EV_CLEAR     = 4'd8,
    EV_FINISHONB = 4'd9,
    EV_STOP      = 4'd10,
    EV_FATAL     = 4'd11,
    EV_WAITQ     = 4'd12
  } event_t;

  typedef enum logic [2:0] {
    LS_STOPPED  = 3'd0,
    LS_UNPROV   = 3'd1,
    LS_CONNECT  = 3'd2,
    LS_ONLINE   = 3'd3,
    LS_BACKOFF  = 3'd4,
    LS_ONB      = 3'd5,
    LS_REJECTED = 3'd6,
    LS_FATAL    = 3'd7
  } link_mode_t;

  localparam int unsigned ActW = 9;
  localparam int unsigned ACT_NETDOWN    = 0;
  localparam int unsigned ACT_NETUP      = 1;
  localparam int unsigned ACT_REQONB     = 2;
  localparam int unsigned ACT_STARTSTA   = 3;
  localparam int unsigned ACT_CONNECT    = 4;
  localparam int unsigned ACT_REJECTCAND = 5;
  localparam int unsigned ACT_STOPSTA    = 6;
  localparam int unsigned ACT_RESTARTSTA = 7;
  localparam int unsigned ACT_STARTCAND  = 8;

  localparam logic [1:0] REG_MIN_BACKOFF = 2'd0;
  localparam logic [1:0] REG_MAX_BACKOFF = 2'd1;
  localparam logic [1:0] REG_AUTH_LIMIT  = 2'd2;

  typedef struct packed {
    logic [19:0] min_backoff;
    logic [19:0] max_backoff;
    logic [4:0]  auth_limit;
  } cfg_t;

  typedef struct packed {
    logic load;
    logic clr_fail;
    logic clr_auth;
    logic bump_auth;
    logic clr_dl;
    logic bo_start;
    logic cap_step;
    logic mod_start;
    logic mod_step;
    logic dl_set;
    logic in_backoff;
  } dp_cmd_t;

  typedef struct packed {
    logic        auth_reach;
    logic        due;
    logic        cap_done;
    logic        mod_last;
    logic [31:0] wait_val;
  } dp_sts_t;

endpackage

@@ hdl/link_reconnect_backoff_fsm_unit.sv @@
// top level of the link reconnect controller with capped exponential backoff
//
// usage
// - input channel (in_valid/in_ready): one event per transfer with its
//   credential and auth flags, current time, jitter and wait ceiling
// - output channel (out_valid/out_ready): exactly one result per event:
//   action flags, new link state and remaining backoff wait
// - config channel (cfg_valid/cfg_ready): always ready; index 0 min backoff,
//   1 max backoff, 2 auth failure limit; other indexes are ignored; write
//   only while idle
// - sequencing: most events go from decode straight to the output register;
//   a disconnect that enters backoff adds the cap doubling loop (at most 20
//   doublings, plus a step to leave it), a bit-serial modulo and a deadline
//   step before the result is registered
// - flow: one event at a time; the next is taken once the result sits in
//   the output register, so a stalled receiver holds at most one waiting
//   result and blocks the input only after that
// - reset: link stopped, all flags, counters and the deadline cleared,
//   registers back to 1000 ms / 60000 ms / 3 failures
module link_reconnect_backoff_fsm_unit
  import lrb_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [3:0]  func,
  input  logic        creds_present,
  input  logic        auth_failed,
  input  logic [63:0] now_ms,
  input  logic [31:0] jitter,
  input  logic [31:0] wait_ceiling_ms,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [8:0]  actions,
  output logic [2:0]  link_state,
  output logic [31:0] wait_ms,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [19:0] cfg_data
);

  cfg_t    cfg;
  dp_cmd_t cmd;
  dp_sts_t sts;

  // config registers, writable at any cycle
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.min_backoff <= 20'd1000;
      cfg.max_backoff <= 20'd60000;
      cfg.auth_limit  <= 5'd3;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_MIN_BACKOFF: cfg.min_backoff <= cfg_data;
        REG_MAX_BACKOFF: cfg.max_backoff <= cfg_data;
        REG_AUTH_LIMIT:  cfg.auth_limit  <= cfg_data[4:0];
        default: ;
      endcase
    end
  end

  // controller: event decode and sequencing
  lrb_ctrl u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .func          (func),
    .creds_present (creds_present),
    .auth_failed   (auth_failed),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .actions       (actions),
    .link_state    (link_state),
    .wait_ms       (wait_ms),
    .cmd           (cmd),
    .sts           (sts)
  );

  // datapath: counters, deadline, backoff arithmetic
  lrb_datapath u_dp (
    .clk             (clk),
    .rst             (rst),
    .cfg             (cfg),
    .cmd             (cmd),
    .now_ms          (now_ms),
    .jitter          (jitter),
    .wait_ceiling_ms (wait_ceiling_ms),
    .sts             (sts)
  );

endmodule

@@ hdl/lrb_datapath.sv @@
// counters, retry deadline, backoff cap doubling and serial modulo
module lrb_datapath
  import lrb_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  cfg_t        cfg,
  input  dp_cmd_t     cmd,
  input  logic [63:0] now_ms,
  input  logic [31:0] jitter,
  input  logic [31:0] wait_ceiling_ms,
  output dp_sts_t     sts
);

  logic [63:0] now_q;
  logic [31:0] jit_q;
  logic [31:0] ceil_q;
  logic [31:0] fail_cnt;
  logic [31:0] auth_cnt;
  logic [63:0] deadline;
  logic [19:0] cap;
  logic [4:0]  idx;
  logic [20:0] rem;
  logic [4:0]  cnt;

  logic [31:0] auth_inc;
  logic [31:0] fail_inc;
  logic [20:0] cap2;
  logic [19:0] lo;
  logic [19:0] span;
  logic [20:0] divisor;
  logic [21:0] shifted;
  logic [63:0] left;

  always_comb begin
    auth_inc = (auth_cnt == '1) ? auth_cnt : auth_cnt + 32'd1;
    fail_inc = (fail_cnt == '1) ? fail_cnt : fail_cnt + 32'd1;
    cap2     = {cap, 1'b0};
    lo       = cap >> 1;
    span     = cap - lo;
    divisor  = {1'b0, span} + 21'd1;
    shifted  = {rem, jit_q[31]};
    left     = deadline - now_q;
  end

  always_comb begin
    sts.auth_reach = auth_inc >= {27'd0, cfg.auth_limit};
    sts.due        = now_q >= deadline;
    sts.cap_done   = !(({27'd0, idx} < fail_cnt) && (cap != '0) &&
                       (cap < cfg.max_backoff));
    sts.mod_last   = cnt == '1;
    if (ceil_q == '0 || !cmd.in_backoff) begin
      sts.wait_val = ceil_q;
    end else if (deadline <= now_q) begin
      sts.wait_val = '0;
    end else if (left < {32'd0, ceil_q}) begin
      sts.wait_val = left[31:0];
    end else begin
      sts.wait_val = ceil_q;
    end
  end

  // item latch and backoff working registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      now_q  <= now_ms;
      ceil_q <= wait_ceiling_ms;
      jit_q  <= jitter;
    end else if (cmd.mod_step) begin
      jit_q <= jit_q << 1;
    end
    if (cmd.bo_start) begin
      cap <= cfg.min_backoff;
      idx <= '0;
    end else if (cmd.cap_step) begin
      cap <= (cap2 > {1'b0, cfg.max_backoff}) ? cfg.max_backoff : cap2[19:0];
      idx <= idx + 5'd1;
    end
    if (cmd.mod_start) begin
      rem <= '0;
      cnt <= '0;
    end else if (cmd.mod_step) begin
      rem <= (shifted >= {1'b0, divisor}) ? 21'(shifted - {1'b0, divisor})
                                          : shifted[20:0];
      cnt <= cnt + 5'd1;
    end
  end

  // controller state held here: failure counters and deadline
  always_ff @(posedge clk) begin
    if (rst) begin
      fail_cnt <= '0;
      auth_cnt <= '0;
      deadline <= '0;
    end else begin
      if (cmd.clr_fail) fail_cnt <= '0;
      else if (cmd.dl_set) fail_cnt <= fail_inc;
      if (cmd.clr_auth) auth_cnt <= '0;
      else if (cmd.bump_auth) auth_cnt <= auth_inc;
      if (cmd.clr_dl) deadline <= '0;
      else if (cmd.dl_set) deadline <= now_q + {44'd0, lo} + {43'd0, rem};
    end
  end

endmodule

@@ hdl/lrb_ctrl.sv @@
// event decode, link mode and flags, sequencer and result register
module lrb_ctrl
  import lrb_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [3:0]        func,
  input  logic              creds_present,
  input  logic              auth_failed,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [ActW-1:0]   actions,
  output logic [2:0]        link_state,
  output logic [31:0]       wait_ms,
  output dp_cmd_t           cmd,
  input  dp_sts_t           sts
);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_EXEC = 6'b000010,
    S_CAP  = 6'b000100,
    S_MOD  = 6'b001000,
    S_DEAD = 6'b010000,
    S_WAIT = 6'b100000
  } seq_t;

  seq_t        state, state_next;
  link_mode_t  mode, mode_next;
  logic        net_up, net_up_next;
  logic        creds, creds_next;
  logic        radio, radio_next;
  logic        cand, cand_next;
  logic        onb, onb_next;
  logic [3:0]  func_q;
  logic        creds_q;
  logic        auth_q;
  logic [ActW-1:0] acts, acts_next;
  logic        go_backoff;
  logic        out_free;

  assign in_ready = state == S_IDLE;
  assign out_free = !out_valid || out_ready;

  always_comb begin
    mode_next   = mode;
    net_up_next = net_up;
    creds_next  = creds;
    radio_next  = radio;
    cand_next   = cand;
    onb_next    = onb;
    acts_next   = '0;
    go_backoff  = 1'b0;
    cmd         = '0;
    cmd.in_backoff = mode == LS_BACKOFF;
    cmd.load    = in_valid && in_ready;
    state_next  = state;

    unique case (state)
      S_IDLE: begin
        if (in_valid) state_next = S_EXEC;
      end
      S_EXEC: begin
        case (func_q)
          EV_START: begin
            if (mode == LS_STOPPED) begin
              creds_next = creds_q;
              if (!creds_q) begin
                mode_next = LS_UNPROV;
                acts_next[ACT_REQONB] = 1'b1;
              end else begin
                mode_next  = LS_CONNECT;
                radio_next = 1'b1;
                acts_next[ACT_STARTSTA] = 1'b1;
              end
            end
          end
          EV_STAUP: begin
            if (mode == LS_CONNECT && creds) begin
              radio_next = 1'b1;
              acts_next[ACT_CONNECT] = 1'b1;
            end
          end
          EV_GOTIP: begin
            if (mode == LS_CONNECT || mode == LS_BACKOFF) begin
              mode_next   = LS_ONLINE;
              net_up_next = 1'b1;
              if (cand) begin
                creds_next = 1'b1;
                cand_next  = 1'b0;
              end
              cmd.clr_fail = 1'b1;
              cmd.clr_auth = 1'b1;
              cmd.clr_dl   = 1'b1;
              acts_next[ACT_NETUP] = 1'b1;
            end
          end
          EV_DISC: begin
            if ((onb && cand && mode == LS_CONNECT) ||
                (creds && (mode == LS_CONNECT || mode == LS_ONLINE ||
                           mode == LS_BACKOFF))) begin
              acts_next[ACT_NETDOWN] = net_up;
              net_up_next = 1'b0;
              if (onb && cand) begin
                cand_next  = 1'b0;
                radio_next = 1'b0;
                mode_next  = LS_ONB;
                cmd.clr_dl   = 1'b1;
                cmd.clr_fail = 1'b1;
                cmd.bump_auth = auth_q;
                acts_next[ACT_REJECTCAND] = 1'b1;
              end else if (auth_q && sts.auth_reach) begin
                cmd.bump_auth = 1'b1;
                mode_next  = LS_REJECTED;
                radio_next = 1'b0;
                cmd.clr_dl = 1'b1;
                acts_next[ACT_STOPSTA] = 1'b1;
                acts_next[ACT_REQONB]  = 1'b1;
              end else begin
                cmd.bump_auth = auth_q;
                cmd.clr_auth  = !auth_q;
                mode_next  = LS_BACKOFF;
                go_backoff = 1'b1;
              end
            end
          end
          EV_POLL: begin
            if (mode == LS_BACKOFF && sts.due) begin
              cmd.clr_dl = 1'b1;
              mode_next  = LS_CONNECT;
              acts_next[ACT_CONNECT] = 1'b1;
            end
          end
          EV_RECOVER: begin
            if (creds && !onb && (mode == LS_CONNECT || mode == LS_BACKOFF)) begin
              acts_next[ACT_NETDOWN] = net_up;
              net_up_next = 1'b0;
              mode_next   = LS_CONNECT;
              radio_next  = 1'b1;
              cmd.clr_dl   = 1'b1;
              cmd.clr_fail = 1'b1;
              cmd.clr_auth = 1'b1;
              acts_next[ACT_RESTARTSTA] = 1'b1;
            end
          end
          EV_BEGINONB: begin
            if (mode != LS_STOPPED && mode != LS_FATAL) begin
              acts_next[ACT_NETDOWN] = net_up;
              net_up_next = 1'b0;
              acts_next[ACT_STOPSTA] = radio;
              radio_next = 1'b0;
              mode_next  = LS_ONB;
              onb_next   = 1'b1;
              cand_next  = 1'b0;
              cmd.clr_dl   = 1'b1;
              cmd.clr_fail = 1'b1;
              cmd.clr_auth = 1'b1;
              acts_next[ACT_REQONB] = 1'b1;
            end
          end
          EV_CAND: begin
            if (mode == LS_ONB && onb && !cand) begin
              cand_next  = 1'b1;
              radio_next = 1'b1;
              mode_next  = LS_CONNECT;
              cmd.clr_dl   = 1'b1;
              cmd.clr_fail = 1'b1;
              cmd.clr_auth = 1'b1;
              acts_next[ACT_STARTCAND] = 1'b1;
            end
          end
          EV_CLEAR: begin
            if (mode == LS_ONB) begin
              creds_next  = 1'b0;
              cand_next   = 1'b0;
              radio_next  = 1'b0;
              net_up_next = 1'b0;
              cmd.clr_dl  = 1'b1;
              acts_next[ACT_REQONB] = 1'b1;
            end
          end
          EV_FINISHONB: begin
            if (onb) begin
              onb_next  = 1'b0;
              cand_next = 1'b0;
              cmd.clr_dl   = 1'b1;
              cmd.clr_fail = 1'b1;
              cmd.clr_auth = 1'b1;
              if (mode == LS_ONLINE && net_up && creds) begin
                radio_next = 1'b1;
              end else begin
                acts_next[ACT_NETDOWN] = net_up;
                net_up_next = 1'b0;
                if (creds) begin
                  radio_next = 1'b1;
                  mode_next  = LS_CONNECT;
                  acts_next[ACT_STARTSTA] = 1'b1;
                end else begin
                  radio_next = 1'b0;
                  mode_next  = LS_UNPROV;
                  acts_next[ACT_REQONB] = 1'b1;
                end
              end
            end
          end
          EV_STOP, EV_FATAL: begin
            if (func_q == EV_FATAL || mode != LS_STOPPED) begin
              acts_next[ACT_NETDOWN] = net_up;
              net_up_next = 1'b0;
              acts_next[ACT_STOPSTA] = radio || onb;
              radio_next = 1'b0;
              onb_next   = 1'b0;
              cand_next  = 1'b0;
              mode_next  = (func_q == EV_FATAL) ? LS_FATAL : LS_STOPPED;
              cmd.clr_dl = 1'b1;
            end
          end
          default: ;
        endcase
        cmd.bo_start = go_backoff;
        state_next = go_backoff ? S_CAP : S_WAIT;
      end
      S_CAP: begin
        if (sts.cap_done) begin
          cmd.mod_start = 1'b1;
          state_next = S_MOD;
        end else begin
          cmd.cap_step = 1'b1;
        end
      end
      S_MOD: begin
        cmd.mod_step = 1'b1;
        if (sts.mod_last) state_next = S_DEAD;
      end
      S_DEAD: begin
        cmd.dl_set = 1'b1;
        state_next = S_WAIT;
      end
      S_WAIT: begin
        if (out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      mode      <= LS_STOPPED;
      net_up    <= 1'b0;
      creds     <= 1'b0;
      radio     <= 1'b0;
      cand      <= 1'b0;
      onb       <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state  <= state_next;
      mode   <= mode_next;
      net_up <= net_up_next;
      creds  <= creds_next;
      radio  <= radio_next;
      cand   <= cand_next;
      onb    <= onb_next;
      if (state == S_WAIT && out_free) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      func_q  <= func;
      creds_q <= creds_present;
      auth_q  <= auth_failed;
    end
    if (state == S_EXEC) acts <= acts_next;
    if (state == S_WAIT && out_free) begin
      actions    <= acts;
      link_state <= mode;
      wait_ms    <= sts.wait_val;
    end
  end

endmodule
